// ===== src/stxl_pkg.sv =====
package stxl_pkg;

    localparam int POS_WIDTH   = 16;
    localparam int KW_MAX_LEN  = 6;
    localparam int KW_TEXT_LEN = 6;
    localparam int KW_COUNT    = 15;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // result queue: an item may push two tokens, so it is taken only with two free slots
    localparam int TQ_DEPTH = 4;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);

    typedef enum logic [1:0] {
        M_IDLE = 2'd0,
        M_WORD = 2'd1,
        M_NUM  = 2'd2,
        M_OP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_AMP   = 3'd0,
        OP_BAR   = 3'd1,
        OP_PLUS  = 3'd2,
        OP_MINUS = 3'd3,
        OP_EQ    = 3'd4,
        OP_LT    = 3'd5,
        OP_GT    = 3'd6
    } t_op;

    typedef enum logic [5:0] {
        K_DATATYPE    = 6'd0,
        K_IDENT       = 6'd1,
        K_NUMBER      = 6'd2,
        K_ASSIGN      = 6'd3,
        K_SEMI        = 6'd4,
        K_OPEN_PAREN  = 6'd5,
        K_CLOSE_PAREN = 6'd6,
        K_OPEN_BRACE  = 6'd7,
        K_CLOSE_BRACE = 6'd8,
        K_AMP         = 6'd9,
        K_BAR         = 6'd10,
        K_COMMA       = 6'd11,
        K_STAR        = 6'd12,
        K_UNDERSCORE  = 6'd13,
        K_LOGIC_AND   = 6'd14,
        K_LOGIC_OR    = 6'd15,
        K_LOGIC_NEG   = 6'd16,
        K_RETURN      = 6'd17,
        K_EQUAL       = 6'd18,
        K_LESS        = 6'd19,
        K_GREATER     = 6'd20,
        K_LESS_EQ     = 6'd21,
        K_GREATER_EQ  = 6'd22,
        K_SHIFT_L     = 6'd23,
        K_SHIFT_R     = 6'd24,
        K_PLUS        = 6'd25,
        K_MINUS       = 6'd26,
        K_DIV         = 6'd27,
        K_PERCENT     = 6'd28,
        K_PLUS_PLUS   = 6'd29,
        K_MINUS_MINUS = 6'd30,
        K_IF          = 6'd31,
        K_ELSE        = 6'd32,
        K_WHILE       = 6'd33,
        K_FOR         = 6'd34,
        K_ERROR       = 6'd35
    } t_kind;

    typedef logic [KW_MAX_LEN-1:0][7:0] t_head;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start_pos;
        logic [15:0] text_len;
        logic        run_end;
    } t_token;

    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_tok_push;

    // keyword text is right-justified: first character in the most significant used byte
    typedef struct packed {
        logic [8*KW_TEXT_LEN-1:0] text;
        logic [2:0]               len;
        t_kind                    kind;
    } t_kw;

    localparam t_kw KW_TABLE [KW_COUNT] = '{
        '{text: 48'("int8"),   len: 3'd4, kind: K_DATATYPE},
        '{text: 48'("int16"),  len: 3'd5, kind: K_DATATYPE},
        '{text: 48'("int32"),  len: 3'd5, kind: K_DATATYPE},
        '{text: 48'("int64"),  len: 3'd5, kind: K_DATATYPE},
        '{text: 48'("void"),   len: 3'd4, kind: K_DATATYPE},
        '{text: 48'("int8*"),  len: 3'd5, kind: K_DATATYPE},
        '{text: 48'("int16*"), len: 3'd6, kind: K_DATATYPE},
        '{text: 48'("int32*"), len: 3'd6, kind: K_DATATYPE},
        '{text: 48'("int64*"), len: 3'd6, kind: K_DATATYPE},
        '{text: 48'("void*"),  len: 3'd5, kind: K_DATATYPE},
        '{text: 48'("return"), len: 3'd6, kind: K_RETURN},
        '{text: 48'("if"),     len: 3'd2, kind: K_IF},
        '{text: 48'("else"),   len: 3'd4, kind: K_ELSE},
        '{text: 48'("while"),  len: 3'd5, kind: K_WHILE},
        '{text: 48'("for"),    len: 3'd3, kind: K_FOR}
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "&" || c == "|" || c == "+" || c == "-" || c == "=" || c == "<"
            || c == ">";
    endfunction

    function automatic t_op op_code(input logic [7:0] c);
        t_op op;
        case (c)
            "|":     op = OP_BAR;
            "+":     op = OP_PLUS;
            "-":     op = OP_MINUS;
            "=":     op = OP_EQ;
            "<":     op = OP_LT;
            ">":     op = OP_GT;
            default: op = OP_AMP;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] op_char(input t_op op);
        logic [7:0] c;
        case (op)
            OP_AMP:   c = "&";
            OP_BAR:   c = "|";
            OP_PLUS:  c = "+";
            OP_MINUS: c = "-";
            OP_EQ:    c = "=";
            OP_LT:    c = "<";
            OP_GT:    c = ">";
            default:  c = "&";
        endcase
        return c;
    endfunction

    function automatic t_kind op_single(input t_op op);
        t_kind k;
        case (op)
            OP_AMP:   k = K_AMP;
            OP_BAR:   k = K_BAR;
            OP_PLUS:  k = K_PLUS;
            OP_MINUS: k = K_MINUS;
            OP_EQ:    k = K_ASSIGN;
            OP_LT:    k = K_LESS;
            OP_GT:    k = K_GREATER;
            default:  k = K_AMP;
        endcase
        return k;
    endfunction

    function automatic t_kind op_double(input t_op op);
        t_kind k;
        case (op)
            OP_AMP:   k = K_LOGIC_AND;
            OP_BAR:   k = K_LOGIC_OR;
            OP_PLUS:  k = K_PLUS_PLUS;
            OP_MINUS: k = K_MINUS_MINUS;
            OP_EQ:    k = K_EQUAL;
            OP_LT:    k = K_SHIFT_L;
            OP_GT:    k = K_SHIFT_R;
            default:  k = K_LOGIC_AND;
        endcase
        return k;
    endfunction

    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            ";":     k = K_SEMI;
            "(":     k = K_OPEN_PAREN;
            ")":     k = K_CLOSE_PAREN;
            "{":     k = K_OPEN_BRACE;
            "}":     k = K_CLOSE_BRACE;
            "_":     k = K_UNDERSCORE;
            ",":     k = K_COMMA;
            "*":     k = K_STAR;
            "/":     k = K_DIV;
            "%":     k = K_PERCENT;
            "~":     k = K_LOGIC_NEG;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // only the first cnt bytes of the head belong to the current word
    function automatic t_kind kw_kind(input t_head head, input logic [15:0] cnt);
        t_kind k;
        logic  hit;
        int    len;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            len = int'(KW_TABLE[i].len);
            hit = (cnt == 16'(len));
            for (int j = 0; j < KW_TEXT_LEN; j++) begin
                if (j < len) begin
                    if (head[j] != KW_TABLE[i].text[8*(len-1-j) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                k = KW_TABLE[i].kind;
            end
        end
        return k;
    endfunction

    function automatic t_head head_put(input t_head head, input logic [15:0] cnt,
                                       input logic [7:0] c);
        t_head h;
        h = head;
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (cnt == 16'(j)) begin
                h[j] = c;
            end
        end
        return h;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
        return (cnt == LEN_MAX) ? cnt : cnt + 16'd1;
    endfunction

    function automatic t_token mk_tok(input t_kind kind, input logic [POS_WIDTH-1:0] start,
                                      input logic [15:0] len);
        t_token                  t;
        logic [POS_WIDTH+15:0]   ext;
        ext         = {16'b0, start};
        t.kind      = kind;
        t.start_pos = ext[15:0];
        t.text_len  = len;
        t.run_end   = 1'b0;
        return t;
    endfunction

endpackage

// ===== src/stxl_if.sv =====
interface stxl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface stxl_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] text_len;
    logic        run_end;

    modport source (output valid, output token_kind, output start_pos, output text_len,
                    output run_end, input ready);
    modport sink   (input valid, input token_kind, input start_pos, input text_len,
                    input run_end, output ready);
endinterface

// ===== src/source_text_lexer_core.sv =====
// Streaming lexer: one source character per transaction in, tokens out.
// i_char carries char_in and end_of_text; a set end_of_text marks the last
// character of a text and flushes any pending word, number or operator.
// o_tok carries token_kind, start_pos, text_len and run_end; run_end is set
// on the last token caused by a character. A character may cause no token,
// one, or two.
// A token enters the token queue when the character that ends it is taken.
// Throughput: one character per cycle while each character yields at most
// one token and the receiver does not stall; characters that yield two fill
// the queue faster than it drains. The rate is set by the single-pop token
// queue (four entries): a character is taken only while two slots are free.
// Reset: scanner idle, position 0, queue empty, nothing offered.
// Receiver stall: tokens wait in the queue and ready drops once it holds more
// than two; nothing is lost or reordered. After end_of_text the position
// restarts at 0 for the next text.
module source_text_lexer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stxl_char_if.sink        i_char,
    stxl_tok_if.source       o_tok
);

    stxl_pkg::t_mode                   r_mode, n_mode;
    stxl_pkg::t_op                     r_op, n_op;
    stxl_pkg::t_head                   r_head, n_head;
    logic [15:0]                       r_cnt, n_cnt;
    logic [stxl_pkg::POS_WIDTH-1:0]    r_start, n_start;
    logic [stxl_pkg::POS_WIDTH-1:0]    r_pos, n_pos;

    logic                              in_fire;
    logic [7:0]                        ch;
    logic                              last;
    logic                              used;
    logic                              pair;
    stxl_pkg::t_kind                   pair_kind;
    logic                              a_v, b_v, c_v;
    stxl_pkg::t_token                  tok_a, tok_b, tok_c;
    logic [1:0]                        tok_cnt;
    stxl_pkg::t_tok_push               push;
    stxl_pkg::t_token                  q_head;
    logic [stxl_pkg::TQ_AW:0]          q_count;

    assign ch      = i_char.char_in;
    assign last    = i_char.end_of_text;
    assign in_fire = i_char.valid && i_char.ready;

    always_comb begin
        n_mode    = r_mode;
        n_op      = r_op;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_start   = r_start;
        used      = 1'b0;
        pair      = 1'b0;
        pair_kind = stxl_pkg::op_double(r_op);
        a_v       = 1'b0;
        b_v       = 1'b0;
        c_v       = 1'b0;
        tok_a     = '0;
        tok_b     = '0;
        tok_c     = '0;

        // continue or close the pending token
        case (r_mode)
            stxl_pkg::M_WORD: begin
                if (stxl_pkg::is_alpha(ch) || stxl_pkg::is_digit(ch) || ch == "_") begin
                    n_head = stxl_pkg::head_put(n_head, n_cnt, ch);
                    n_cnt  = stxl_pkg::sat_inc(n_cnt);
                    used   = 1'b1;
                end else if (ch == "*") begin
                    // trailing star belongs to the word and closes it
                    n_head = stxl_pkg::head_put(n_head, n_cnt, ch);
                    n_cnt  = stxl_pkg::sat_inc(n_cnt);
                    a_v    = 1'b1;
                    tok_a  = stxl_pkg::mk_tok(stxl_pkg::kw_kind(n_head, n_cnt), r_start, n_cnt);
                    n_mode = stxl_pkg::M_IDLE;
                    used   = 1'b1;
                end else begin
                    a_v    = 1'b1;
                    tok_a  = stxl_pkg::mk_tok(stxl_pkg::kw_kind(r_head, r_cnt), r_start, r_cnt);
                    n_mode = stxl_pkg::M_IDLE;
                end
            end
            stxl_pkg::M_NUM: begin
                if (stxl_pkg::is_digit(ch)) begin
                    n_cnt = stxl_pkg::sat_inc(n_cnt);
                    used  = 1'b1;
                end else begin
                    a_v    = 1'b1;
                    tok_a  = stxl_pkg::mk_tok(stxl_pkg::K_NUMBER, r_start, r_cnt);
                    n_mode = stxl_pkg::M_IDLE;
                end
            end
            stxl_pkg::M_OP: begin
                case (r_op)
                    stxl_pkg::OP_LT: pair = (ch == "=") || (ch == "<");
                    stxl_pkg::OP_GT: pair = (ch == "=") || (ch == ">");
                    default:         pair = (ch == stxl_pkg::op_char(r_op));
                endcase
                if (r_op == stxl_pkg::OP_LT && ch == "=") begin
                    pair_kind = stxl_pkg::K_LESS_EQ;
                end else if (r_op == stxl_pkg::OP_GT && ch == "=") begin
                    pair_kind = stxl_pkg::K_GREATER_EQ;
                end
                a_v    = 1'b1;
                n_mode = stxl_pkg::M_IDLE;
                if (pair) begin
                    tok_a = stxl_pkg::mk_tok(pair_kind, r_start, 16'd2);
                    used  = 1'b1;
                end else begin
                    tok_a = stxl_pkg::mk_tok(stxl_pkg::op_single(r_op), r_start, 16'd1);
                end
            end
            default: ;
        endcase

        // character not absorbed: it opens a new token
        if (!used) begin
            if (stxl_pkg::is_space(ch)) begin
                n_mode = n_mode;
            end else if (stxl_pkg::is_alpha(ch)) begin
                n_mode  = stxl_pkg::M_WORD;
                n_head  = stxl_pkg::head_put(n_head, 16'd0, ch);
                n_cnt   = 16'd1;
                n_start = r_pos;
            end else if (stxl_pkg::is_digit(ch)) begin
                n_mode  = stxl_pkg::M_NUM;
                n_cnt   = 16'd1;
                n_start = r_pos;
            end else if (stxl_pkg::is_op(ch)) begin
                n_mode  = stxl_pkg::M_OP;
                n_op    = stxl_pkg::op_code(ch);
                n_cnt   = 16'd1;
                n_start = r_pos;
            end else begin
                b_v   = 1'b1;
                tok_b = stxl_pkg::mk_tok(stxl_pkg::single_kind(ch), r_pos, 16'd1);
            end
        end

        if (last) begin
            case (n_mode)
                stxl_pkg::M_WORD: begin
                    c_v   = 1'b1;
                    tok_c = stxl_pkg::mk_tok(stxl_pkg::kw_kind(n_head, n_cnt), n_start, n_cnt);
                end
                stxl_pkg::M_NUM: begin
                    c_v   = 1'b1;
                    tok_c = stxl_pkg::mk_tok(stxl_pkg::K_NUMBER, n_start, n_cnt);
                end
                stxl_pkg::M_OP: begin
                    c_v   = 1'b1;
                    tok_c = stxl_pkg::mk_tok(stxl_pkg::op_single(n_op), n_start, 16'd1);
                end
                default: ;
            endcase
            n_mode = stxl_pkg::M_IDLE;
            n_pos  = '0;
        end else begin
            n_pos = r_pos + stxl_pkg::POS_WIDTH'(1);
        end
    end

    // b and c never both fire: a new pending token excludes an immediate single token
    always_comb begin
        tok_cnt           = {1'b0, a_v} + {1'b0, b_v || c_v};
        push.cnt          = in_fire ? tok_cnt : 2'd0;
        push.tok0         = a_v ? tok_a : (b_v ? tok_b : tok_c);
        push.tok1         = b_v ? tok_b : tok_c;
        push.tok0.run_end = (tok_cnt == 2'd1);
        push.tok1.run_end = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stxl_pkg::M_IDLE;
            r_op   <= stxl_pkg::OP_AMP;
            r_cnt  <= '0;
            r_pos  <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_head  <= n_head;
            r_start <= n_start;
        end
    end

    stxl_tok_fifo u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_tok.valid && o_tok.ready),
        .o_head  (q_head),
        .o_count (q_count)
    );

    assign i_char.ready     = (q_count <= (stxl_pkg::TQ_AW+1)'(stxl_pkg::TQ_DEPTH - 2));
    assign o_tok.valid      = (q_count != '0);
    assign o_tok.token_kind = q_head.kind;
    assign o_tok.start_pos  = q_head.start_pos;
    assign o_tok.text_len   = q_head.text_len;
    assign o_tok.run_end    = q_head.run_end;

    a_text_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_char.end_of_text) |=> (r_pos == '0 && r_mode == stxl_pkg::M_IDLE))
        else $error("scanner not back at start after end of text");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (stxl_pkg::TQ_AW+1)'(stxl_pkg::TQ_DEPTH))
        else $error("token queue overflow");

    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != stxl_pkg::M_IDLE) |-> (r_cnt != 16'd0))
        else $error("pending token with zero length");

endmodule

// ===== src/stxl_tok_fifo.sv =====
module stxl_tok_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stxl_pkg::t_tok_push   i_push,
    input  logic                  i_pop,
    output stxl_pkg::t_token      o_head,
    output logic [stxl_pkg::TQ_AW:0] o_count
);

    stxl_pkg::t_token              r_mem [stxl_pkg::TQ_DEPTH];
    logic [stxl_pkg::TQ_AW-1:0]    r_wr;
    logic [stxl_pkg::TQ_AW-1:0]    r_rd;
    logic [stxl_pkg::TQ_AW:0]      r_count;
    logic [stxl_pkg::TQ_AW-1:0]    wr_next;

    assign wr_next = r_wr + stxl_pkg::TQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + stxl_pkg::TQ_AW'(i_push.cnt);
            r_rd    <= r_rd + stxl_pkg::TQ_AW'(i_pop);
            r_count <= r_count + (stxl_pkg::TQ_AW+1)'(i_push.cnt)
                               - (stxl_pkg::TQ_AW+1)'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule
